// ===== rtl/stsum_pkg.sv =====
`default_nettype none

package stsum_pkg;

  localparam int IDX_W   = 12;
  localparam int VALUE_W = 32;
  localparam int START_W = 12;
  localparam int END_W   = 13;
  localparam int SUM_W   = 48;
  localparam int CFG_W   = 13;

  localparam logic [CFG_W-1:0] LEAF_COUNT_RESET = 13'd4096;

  localparam logic OP_SET   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_SET,
    S_QLO,
    S_QHI,
    S_DONE
  } stsum_state_t;

  typedef struct packed {
    logic                      op;
    logic [IDX_W-1:0]          leaf_index;
    logic signed [VALUE_W-1:0] leaf_value;
    logic [START_W-1:0]        range_start;
    logic [END_W-1:0]          range_end;
  } stsum_cmd_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] range_sum;
    logic                    range_error;
  } stsum_res_t;

endpackage

`default_nettype wire

// ===== rtl/stsum_in_if.sv =====
`default_nettype none

interface stsum_in_if;
  import stsum_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      op;
  logic [IDX_W-1:0]          leaf_index;
  logic signed [VALUE_W-1:0] leaf_value;
  logic [START_W-1:0]        range_start;
  logic [END_W-1:0]          range_end;

  modport source (
    output valid, op, leaf_index, leaf_value, range_start, range_end,
    input  ready
  );

  modport sink (
    input  valid, op, leaf_index, leaf_value, range_start, range_end,
    output ready
  );

endinterface

`default_nettype wire

// ===== rtl/stsum_out_if.sv =====
`default_nettype none

interface stsum_out_if;
  import stsum_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [SUM_W-1:0] range_sum;
  logic                    range_error;

  modport source (
    output valid, range_sum, range_error,
    input  ready
  );

  modport sink (
    input  valid, range_sum, range_error,
    output ready
  );

endinterface

`default_nettype wire

// ===== rtl/stsum_engine.sv =====
`default_nettype none

module stsum_engine #(
  parameter int  MAX_LEAVES = 4096,
  localparam int DEPTH      = 2 * MAX_LEAVES,
  localparam int AW         = $clog2(DEPTH),
  localparam int NW         = AW + 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [NW-1:0]          n_eff,
  input  logic                   req_valid,
  output logic                   req_ready,
  input  stsum_pkg::stsum_cmd_t  req,
  output logic                   res_valid,
  input  logic                   res_ready,
  output stsum_pkg::stsum_res_t  res
);
  import stsum_pkg::*;

  stsum_state_t state_r, state_nxt;

  logic [AW-1:0]    clr_addr_r, clr_addr_nxt;
  logic             pend_r, pend_nxt;
  logic [NW-1:0]    node_r, node_nxt;   // set: current node; query: lo
  logic [NW-1:0]    hi_r, hi_nxt;
  logic [SUM_W-1:0] acc_r, acc_nxt;
  logic             err_r, err_nxt;

  logic [SUM_W-1:0] mem [DEPTH];
  logic [SUM_W-1:0] rdata_r;
  logic             mem_we, mem_re;
  logic [AW-1:0]    mem_waddr, mem_raddr;
  logic [SUM_W-1:0] mem_wdata;

  logic [NW-1:0]    set_node, parent, q_lo, q_hi, hi_dec;
  logic             set_ok, q_bad;
  logic [SUM_W-1:0] set_val, sum_up, acc_add;

  assign set_node = NW'(req.leaf_index) + n_eff;
  assign set_ok   = 32'(req.leaf_index) < 32'(n_eff);
  assign set_val  = {{(SUM_W-VALUE_W){req.leaf_value[VALUE_W-1]}}, req.leaf_value};
  assign q_lo     = NW'(req.range_start) + n_eff;
  assign q_hi     = NW'(req.range_end) + n_eff;
  assign q_bad    = (req.range_start > START_W'(0) && 32'(req.range_start) > 32'(req.range_end))
                    || (32'(req.range_end) > 32'(n_eff));
  assign parent   = node_r >> 1;
  assign sum_up   = acc_r + rdata_r;
  assign acc_add  = acc_r + (pend_r ? rdata_r : '0);
  assign hi_dec   = hi_r[0] ? hi_r - NW'(1) : hi_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLR: begin
        if (clr_addr_r == AW'(DEPTH - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid) begin
          if (req.op == OP_SET) begin
            if (set_ok && set_node > NW'(1)) state_nxt = S_SET;
          end else if (q_bad) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_QLO;
          end
        end
      end
      S_SET: begin
        if (parent <= NW'(1)) state_nxt = S_IDLE;
      end
      S_QLO: begin
        state_nxt = (node_r < hi_r) ? S_QHI : S_DONE;
      end
      S_QHI: begin
        state_nxt = S_QLO;
      end
      S_DONE: begin
        if (res_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_CLR;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    clr_addr_nxt = clr_addr_r;
    pend_nxt     = 1'b0;
    node_nxt     = node_r;
    hi_nxt       = hi_r;
    acc_nxt      = acc_r;
    err_nxt      = err_r;
    mem_we       = 1'b0;
    mem_waddr    = '0;
    mem_wdata    = '0;
    mem_re       = 1'b0;
    mem_raddr    = '0;
    req_ready    = 1'b0;
    res_valid    = 1'b0;
    case (state_r)
      S_CLR: begin
        mem_we       = 1'b1;
        mem_waddr    = clr_addr_r;
        clr_addr_nxt = clr_addr_r + AW'(1);
      end
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          if (req.op == OP_SET) begin
            if (set_ok) begin
              mem_we    = 1'b1;
              mem_waddr = AW'(set_node);
              mem_wdata = set_val;
              acc_nxt   = set_val;
              node_nxt  = set_node;
              mem_re    = set_node > NW'(1);
              mem_raddr = AW'(set_node ^ NW'(1));
            end
          end else if (q_bad) begin
            acc_nxt = '0;
            err_nxt = 1'b1;
          end else begin
            node_nxt = q_lo;
            hi_nxt   = q_hi;
            acc_nxt  = '0;
            err_nxt  = 1'b0;
          end
        end
      end
      S_SET: begin
        // sibling arrived; write parent, fetch parent's sibling
        mem_we    = 1'b1;
        mem_waddr = AW'(parent);
        mem_wdata = sum_up;
        acc_nxt   = sum_up;
        node_nxt  = parent;
        mem_re    = parent > NW'(1);
        mem_raddr = AW'(parent ^ NW'(1));
      end
      S_QLO: begin
        acc_nxt = acc_add;
        if (node_r < hi_r && node_r[0]) begin
          mem_re    = 1'b1;
          mem_raddr = AW'(node_r);
          node_nxt  = node_r + NW'(1);
          pend_nxt  = 1'b1;
        end
      end
      S_QHI: begin
        acc_nxt = acc_add;
        if (hi_r[0]) begin
          mem_re    = 1'b1;
          mem_raddr = AW'(hi_dec);
          pend_nxt  = 1'b1;
        end
        node_nxt = node_r >> 1;
        hi_nxt   = hi_dec >> 1;
      end
      S_DONE: begin
        res_valid = 1'b1;
      end
      default: ;
    endcase
  end

  assign res.range_sum   = acc_r;
  assign res.range_error = err_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLR;
      clr_addr_r <= '0;
      pend_r     <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      pend_r     <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    node_r <= node_nxt;
    hi_r   <= hi_nxt;
    acc_r  <= acc_nxt;
    err_r  <= err_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_r <= mem[mem_raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/segment_tree_point_set_range_sum_top.sv =====
// Point-set / range-sum segment tree over up to MAX_LEAVES leaves of signed Q16.16.
// in_ch: one beat per item. op = set writes leaf_value (sign-extended to 48 bits)
//   at leaf_index and rebuilds its ancestors; no result beat. A set at or above
//   the leaf count is dropped. op = query sums leaves [range_start, range_end)
//   and gives one out_ch beat with range_sum and range_error (bad range: sum 0).
// cfg_we/cfg_wdata load the leaf count (0 acts as 1, above MAX_LEAVES clamps).
//   Write it only while the block is idle; the tree store is not cleared.
// Structure: all nodes sit in one memory with one read and one write port.
//   A set walks from the leaf up to the root; each level is a sibling read
//   overlapped with the parent write. A query walks up the levels with one read
//   slot each for the left and right border (states S_QLO and S_QHI).
//   One item is in flight at a time.
// Reset: a clearing pass writes zero to all 2*MAX_LEAVES nodes, one per cycle;
//   in_ch.ready stays low for those cycles.
// out_ch is registered: a finished result waits there while out_ch.ready is low
//   and the next item is still accepted; a second result waits in the engine.
`default_nettype none

module segment_tree_point_set_range_sum_top #(
  parameter int MAX_LEAVES = 4096
) (
  input  logic                        clk,
  input  logic                        rst_n,
  stsum_in_if.sink                    in_ch,
  stsum_out_if.source                 out_ch,
  input  logic                        cfg_we,
  input  logic [stsum_pkg::CFG_W-1:0] cfg_wdata
);
  import stsum_pkg::*;

  localparam int NW = $clog2(2 * MAX_LEAVES) + 1;

  logic [CFG_W-1:0] leaf_count_r;
  logic [NW-1:0]    n_eff;

  stsum_cmd_t req;
  stsum_res_t res, out_r;
  logic       res_valid, res_ready;
  logic       out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      leaf_count_r <= LEAF_COUNT_RESET;
    end else if (cfg_we) begin
      leaf_count_r <= cfg_wdata;
    end
  end

  always_comb begin
    if (leaf_count_r == '0) begin
      n_eff = NW'(1);
    end else if (32'(leaf_count_r) > MAX_LEAVES) begin
      n_eff = NW'(MAX_LEAVES);
    end else begin
      n_eff = NW'(leaf_count_r);
    end
  end

  assign req.op          = in_ch.op;
  assign req.leaf_index  = in_ch.leaf_index;
  assign req.leaf_value  = in_ch.leaf_value;
  assign req.range_start = in_ch.range_start;
  assign req.range_end   = in_ch.range_end;

  stsum_engine #(
    .MAX_LEAVES (MAX_LEAVES)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .n_eff     (n_eff),
    .req_valid (in_ch.valid),
    .req_ready (in_ch.ready),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign res_ready = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) out_r <= res;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.range_sum   = out_r.range_sum;
  assign out_ch.range_error = out_r.range_error;

endmodule

`default_nettype wire

// ===== rtl/stsum_chk.sv =====
`default_nettype none

module stsum_chk (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  logic                               in_op,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  logic signed [stsum_pkg::SUM_W-1:0] out_sum,
  input  logic                               out_err
);
  import stsum_pkg::*;

  // clearing pass follows every reset
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_ready && !out_valid)
    else $error("block ready or output valid right after reset");

  // one query at a time: the engine is busy the cycle after a query beat
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_op == OP_QUERY |=> !in_ready)
    else $error("input accepted right after a query beat");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_err |-> out_sum == '0)
    else $error("bad range with nonzero sum");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sum) && $stable(out_err))
    else $error("stalled result beat changed");

endmodule

bind segment_tree_point_set_range_sum_top stsum_chk u_stsum_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_op     (in_ch.op),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_sum   (out_ch.range_sum),
  .out_err   (out_ch.range_error)
);

`default_nettype wire
